// ===== hw/rtl/rtcf_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcf_pkg
// Types and constants shared by the topology change machine modules.
// ----------------------------------------------------------------------------
package rtcf_pkg;

   // machine states, in the order of the fsm_state codes
   typedef enum logic [2:0] {
      ST_INIT         = 3'd0,
      ST_INACTIVE     = 3'd1,
      ST_TCACTIVE     = 3'd2,
      ST_DETECTED     = 3'd3,
      ST_NOTIFIED_TC  = 3'd4,
      ST_PROPAGATING  = 3'd5,
      ST_ACKNOWLEDGED = 3'd6,
      ST_NOTIFIED_TCN = 3'd7
   } state_type;

   typedef enum logic [1:0] {
      ROLE_DISABLED   = 2'd0,
      ROLE_ROOT       = 2'd1,
      ROLE_DESIGNATED = 2'd2,
      ROLE_ALT_BACKUP = 2'd3
   } role_type;

   // register indexes (paddr[3:2])
   typedef enum logic [1:0] {
      REG_HELLO_TIME    = 2'd0,
      REG_MAX_AGE       = 2'd1,
      REG_FORWARD_DELAY = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int TIMER_WIDTH    = 9;

   localparam logic [7:0] HELLO_TIME_RESET    = 8'd2;
   localparam logic [7:0] MAX_AGE_RESET       = 8'd20;
   localparam logic [7:0] FORWARD_DELAY_RESET = 8'd15;

   typedef struct packed {
      logic [7:0] root_hello_time;
      logic [7:0] root_max_age;
      logic [7:0] root_forward_delay;
   } cfg_type;

   typedef struct packed {
      logic       begin_req;
      logic [1:0] port_role;
      logic       oper_edge;
      logic       send_rstp;
      logic       point_to_point;
      logic       set_tc;
      logic       set_rcvd_tc;
      logic       set_rcvd_tcn;
      logic       set_rcvd_tc_ack;
      logic       set_tc_prop;
      logic       clear_tc_ack;
   } req_type;

   typedef struct packed {
      logic [2:0]             fsm_state;
      logic                   changed;
      logic                   load_tc_while;
      logic [TIMER_WIDTH-1:0] tc_while_value;
      logic                   tc_ack_flag;
      logic                   notify_others;
   } rsp_type;

   // handshake between the machine core and the result buffer
   typedef struct packed {
      logic push;
   } buf_ctl_type;

endpackage

// ===== hw/rtl/rstp_topology_change_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// rstp_topology_change_fsm_unit
// Per-port rapid spanning tree topology change machine with APB registers.
// ----------------------------------------------------------------------------
// Path: an accepted transaction passes the input register, then the state
//   evaluation writes the result buffer, which offers it on rsp_.
// Throughput: one transaction per cycle unless req_stall holds the request;
//   a two-entry result buffer absorbs output stalls.
// Reset (synchronous, active high): machine in INIT, all event flags and
//   tcAck clear, buffers empty, registers at hello 2, max age 20, fwd 15.
// ----------------------------------------------------------------------------
module rstp_topology_change_fsm_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rtcf_pkg::req_type                    req_data,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rtcf_pkg::rsp_type                    rsp_data,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rtcf_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [rtcf_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [rtcf_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import rtcf_pkg::*;

   cfg_type     cfg;       // live timer values; user writes only while idle, unenforced
   buf_ctl_type buf_ctl;   // core push strobe
   rsp_type     result;    // result of the transaction being evaluated
   logic        buf_full;

   // Register bank: hello time, max age and forward delay at 0x0/0x4/0x8.
   rtcf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Core: registers the transaction, folds its pulses into the flags and
   // takes one transition with entry actions. It stalls the request side
   // only when its input register holds a transaction and the buffer is full.
   rtcf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .buf_full  (buf_full),
      .buf_ctl   (buf_ctl),
      .result    (result)
   );

   // Result buffer: keeps the core running while the consumer stalls.
   rtcf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .buf_ctl   (buf_ctl),
      .push_data (result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/rtcf_csr.sv =====
// ----------------------------------------------------------------------------
// rtcf_csr
// APB register bank holding the root bridge timer values.
// ----------------------------------------------------------------------------
module rtcf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rtcf_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [rtcf_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [rtcf_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output rtcf_pkg::cfg_type                    cfg
);
   import rtcf_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write;

   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign write      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            REG_HELLO_TIME:    cfg_in.root_hello_time    = csr_pwdata[7:0];
            REG_MAX_AGE:       cfg_in.root_max_age       = csr_pwdata[7:0];
            REG_FORWARD_DELAY: cfg_in.root_forward_delay = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.root_hello_time    <= HELLO_TIME_RESET;
         cfg_ff.root_max_age       <= MAX_AGE_RESET;
         cfg_ff.root_forward_delay <= FORWARD_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_HELLO_TIME:    csr_prdata = {24'd0, cfg_ff.root_hello_time};
         REG_MAX_AGE:       csr_prdata = {24'd0, cfg_ff.root_max_age};
         REG_FORWARD_DELAY: csr_prdata = {24'd0, cfg_ff.root_forward_delay};
         default:           csr_prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/rtcf_core.sv =====
// ----------------------------------------------------------------------------
// rtcf_core
// Input register, event flags and the topology change state machine.
// ----------------------------------------------------------------------------
module rtcf_core (
   input  logic                  clock,
   input  logic                  reset,
   input  rtcf_pkg::cfg_type     cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rtcf_pkg::req_type     req_data,
   input  logic                  buf_full,
   output rtcf_pkg::buf_ctl_type buf_ctl,
   output rtcf_pkg::rsp_type     result
);
   import rtcf_pkg::*;

   typedef struct packed {
      logic tc;
      logic tc_prop;
      logic rcvd_tc;
      logic rcvd_tcn;
      logic rcvd_tc_ack;
      logic tc_ack;
   } flags_type;

   req_type   in_ff;
   logic      in_valid_ff;
   logic      in_valid_in;
   state_type state_ff;
   state_type state_in;
   state_type nxt;
   flags_type flags_ff;
   flags_type flags_in;
   flags_type f;
   logic      fire;
   logic      accept;
   logic      take;
   logic      active;
   logic      notify;
   logic      load;
   logic [TIMER_WIDTH-1:0] value;
   logic [TIMER_WIDTH-1:0] fresh;

   assign fire      = in_valid_ff && !buf_full;
   assign req_stall = in_valid_ff && buf_full;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= ST_INIT;
         flags_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         flags_ff    <= flags_in;
      end
   end

   assign active = (role_type'(in_ff.port_role) == ROLE_ROOT) ||
                   (role_type'(in_ff.port_role) == ROLE_DESIGNATED);

   // fresh tcWhile: two hello times on a p2p RSTP link, else max age + fwd delay
   assign fresh = (in_ff.send_rstp && in_ff.point_to_point)
                ? {cfg.root_hello_time, 1'b0}
                : {1'b0, cfg.root_max_age} + {1'b0, cfg.root_forward_delay};

   always_comb begin
      // set pulses and the tcAck clear act before the transition
      f.tc          = flags_ff.tc          | in_ff.set_tc;
      f.rcvd_tc     = flags_ff.rcvd_tc     | in_ff.set_rcvd_tc;
      f.rcvd_tcn    = flags_ff.rcvd_tcn    | in_ff.set_rcvd_tcn;
      f.rcvd_tc_ack = flags_ff.rcvd_tc_ack | in_ff.set_rcvd_tc_ack;
      f.tc_prop     = flags_ff.tc_prop     | in_ff.set_tc_prop;
      f.tc_ack      = flags_ff.tc_ack      & ~in_ff.clear_tc_ack;

      take = 1'b0;
      nxt  = state_ff;
      if (in_ff.begin_req) begin
         take = 1'b1;
         nxt  = ST_INIT;
      end else begin
         case (state_ff)
            ST_INIT: begin
               take = 1'b1;
               nxt  = ST_INACTIVE;
            end
            ST_INACTIVE: begin
               if (active) begin
                  take = 1'b1;
                  nxt  = ST_TCACTIVE;
               end else if (f.rcvd_tc || f.rcvd_tcn || f.rcvd_tc_ack ||
                            f.tc || f.tc_prop) begin
                  // re-entry clears the stale events
                  take = 1'b1;
                  nxt  = ST_INACTIVE;
               end
            end
            ST_TCACTIVE: begin
               take = 1'b1;
               if (!active)                           nxt = ST_INIT;
               else if (f.tc)                         nxt = ST_DETECTED;
               else if (f.rcvd_tcn)                   nxt = ST_NOTIFIED_TCN;
               else if (f.rcvd_tc)                    nxt = ST_NOTIFIED_TC;
               else if (f.tc_prop && !in_ff.oper_edge) nxt = ST_PROPAGATING;
               else if (f.rcvd_tc_ack)                nxt = ST_ACKNOWLEDGED;
               else                                   take = 1'b0;
            end
            ST_NOTIFIED_TCN: begin
               take = 1'b1;
               nxt  = ST_NOTIFIED_TC;
            end
            default: begin
               // transient states fall back to TCACTIVE unconditionally
               take = 1'b1;
               nxt  = ST_TCACTIVE;
            end
         endcase
      end

      load     = 1'b0;
      value    = '0;
      notify   = 1'b0;
      flags_in = f;
      if (take) begin
         case (nxt)
            ST_INIT: begin
               load             = 1'b1;
               flags_in.tc      = 1'b0;
               flags_in.tc_prop = 1'b0;
               flags_in.tc_ack  = 1'b0;
            end
            ST_INACTIVE: begin
               flags_in.rcvd_tc     = 1'b0;
               flags_in.rcvd_tcn    = 1'b0;
               flags_in.rcvd_tc_ack = 1'b0;
               flags_in.tc          = 1'b0;
               flags_in.tc_prop     = 1'b0;
            end
            ST_DETECTED: begin
               load        = 1'b1;
               value       = fresh;
               notify      = 1'b1;
               flags_in.tc = 1'b0;
            end
            ST_NOTIFIED_TC: begin
               flags_in.rcvd_tcn = 1'b0;
               flags_in.rcvd_tc  = 1'b0;
               if (role_type'(in_ff.port_role) == ROLE_DESIGNATED) begin
                  flags_in.tc_ack = 1'b1;
               end
               notify = 1'b1;
            end
            ST_PROPAGATING: begin
               load             = 1'b1;
               value            = fresh;
               flags_in.tc_prop = 1'b0;
            end
            ST_ACKNOWLEDGED: begin
               load                 = 1'b1;
               flags_in.rcvd_tc_ack = 1'b0;
            end
            ST_NOTIFIED_TCN: begin
               load  = 1'b1;
               value = fresh;
            end
            default: ;
         endcase
      end

      if (!fire) begin
         flags_in = flags_ff;
         state_in = state_ff;
      end else begin
         state_in = nxt;
      end
   end

   assign result.fsm_state      = nxt;
   assign result.changed        = take;
   assign result.load_tc_while  = load;
   assign result.tc_while_value = value;
   assign result.tc_ack_flag    = flags_in.tc_ack;
   assign result.notify_others  = notify;

   assign buf_ctl.push = fire;

   // stored state tracks the reported state
   a_state_follows: assert property (@(posedge clock) disable iff (reset)
      fire |=> state_ff == state_type'($past(result.fsm_state)))
      else $error("state register does not match reported state");

   a_begin_init: assert property (@(posedge clock) disable iff (reset)
      (fire && in_ff.begin_req) |=> (state_ff == ST_INIT) && !flags_ff.tc_ack)
      else $error("begin did not land in INIT with tcAck clear");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(state_ff) && $stable(flags_ff))
      else $error("machine state moved without a transaction");

   a_no_change_no_load: assert property (@(posedge clock) disable iff (reset)
      (fire && !result.changed) |-> !result.load_tc_while && !result.notify_others)
      else $error("entry action without a transition");

endmodule

// ===== hw/rtl/rtcf_out_buf.sv =====
// ----------------------------------------------------------------------------
// rtcf_out_buf
// Two-entry result buffer between the machine core and the response channel.
// ----------------------------------------------------------------------------
module rtcf_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  rtcf_pkg::buf_ctl_type buf_ctl,
   input  rtcf_pkg::rsp_type     push_data,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rtcf_pkg::rsp_type     rsp_data
);
   import rtcf_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign full      = count_ff == 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ buf_ctl.push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, buf_ctl.push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (buf_ctl.push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
